// File: rtl/core/cbez_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbez_pkg;

  // Field widths fixed by the word formats.
  localparam int COORD_W = 16;
  localparam int T_W     = 11;

  // Default fraction shift applied to the weights and to the final sum.
  localparam int FRAC_SHIFT_DEF = 15;

  // Widths of the weight arithmetic, fixed by the parameter field width.
  localparam int U3_W   = T_W + 2;          // 3 * u
  localparam int SQ_W   = 2 * T_W;          // t*t, u*u
  localparam int TU3_W  = T_W + U3_W;       // 3 * t * u
  localparam int CUBE_W = T_W + TU3_W;      // widest raw weight

  typedef struct packed {
    logic signed [COORD_W-1:0] p0;
    logic signed [COORD_W-1:0] p1;
    logic signed [COORD_W-1:0] p2;
    logic signed [COORD_W-1:0] p3;
    logic        [T_W-1:0]     param_t;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point;
    logic        [T_W-1:0]     one_minus_t;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/cbez_weights.sv
`timescale 1ns / 1ps
`default_nettype none

// Three stages: saturate t and form u and 3u; squares and 3tu; the four
// Bernstein weights, each truncated by FRAC_SHIFT. The coordinates ride along.
module cbez_weights #(
  parameter int FRAC_SHIFT = cbez_pkg::FRAC_SHIFT_DEF,
  parameter int WT_W       = cbez_pkg::CUBE_W - FRAC_SHIFT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    item_valid,
  input  wire cbez_pkg::item_t         item,
  output logic                         wt_valid,
  output logic [3:0][WT_W-1:0]         wt,
  output logic [cbez_pkg::T_W-1:0]     wt_u,
  output cbez_pkg::item_t              wt_item
);
  import cbez_pkg::*;

  localparam int ONE_SHIFT = (2 * FRAC_SHIFT) / 3;
  localparam int ONE       = 1 << ONE_SHIFT;

  // Stage 1
  logic              s1_valid;
  logic [T_W-1:0]    s1_t;
  logic [T_W-1:0]    s1_u;
  logic [U3_W-1:0]   s1_u3;
  item_t             s1_item;
  logic [T_W-1:0]    t_sat;
  logic [T_W-1:0]    u_val;

  // Stage 2
  logic              s2_valid;
  logic [T_W-1:0]    s2_t;
  logic [T_W-1:0]    s2_u;
  logic [SQ_W-1:0]   s2_tt;
  logic [SQ_W-1:0]   s2_uu;
  logic [TU3_W-1:0]  s2_tu3;
  item_t             s2_item;

  // Stage 3 raw weights
  logic [CUBE_W-1:0] raw0;
  logic [CUBE_W-1:0] raw1;
  logic [CUBE_W-1:0] raw2;
  logic [CUBE_W-1:0] raw3;

  always_comb begin
    t_sat = (item.param_t > T_W'(ONE)) ? T_W'(ONE) : item.param_t;
    u_val = T_W'(ONE) - t_sat;
  end

  always_comb begin
    raw0 = CUBE_W'(s2_uu) * CUBE_W'(s2_u);
    raw1 = CUBE_W'(s2_tu3) * CUBE_W'(s2_u);
    raw2 = CUBE_W'(s2_tu3) * CUBE_W'(s2_t);
    raw3 = CUBE_W'(s2_tt) * CUBE_W'(s2_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wt_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      wt_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t    <= t_sat;
      s1_u    <= u_val;
      s1_u3   <= U3_W'(u_val) + (U3_W'(u_val) << 1);
      s1_item <= item;

      s2_t    <= s1_t;
      s2_u    <= s1_u;
      s2_tt   <= SQ_W'(s1_t) * SQ_W'(s1_t);
      s2_uu   <= SQ_W'(s1_u) * SQ_W'(s1_u);
      s2_tu3  <= TU3_W'(s1_t) * TU3_W'(s1_u3);
      s2_item <= s1_item;

      wt[0]   <= WT_W'(raw0 >> FRAC_SHIFT);
      wt[1]   <= WT_W'(raw1 >> FRAC_SHIFT);
      wt[2]   <= WT_W'(raw2 >> FRAC_SHIFT);
      wt[3]   <= WT_W'(raw3 >> FRAC_SHIFT);
      wt_u    <= s2_u;
      wt_item <= s2_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cbez_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Two stages: four signed weight-by-coordinate products, then the sum with a
// floor shift by FRAC_SHIFT into the output register.
module cbez_blend #(
  parameter int FRAC_SHIFT = cbez_pkg::FRAC_SHIFT_DEF,
  parameter int WT_W       = cbez_pkg::CUBE_W - FRAC_SHIFT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    wt_valid,
  input  wire logic [3:0][WT_W-1:0]    wt,
  input  wire logic [cbez_pkg::T_W-1:0] wt_u,
  input  wire cbez_pkg::item_t         wt_item,
  output logic                         result_valid,
  output cbez_pkg::result_t            result
);
  import cbez_pkg::*;

  localparam int PROD_W = WT_W + 1 + COORD_W;
  localparam int SUM_W  = PROD_W + 2;

  logic                     s4_valid;
  logic signed [PROD_W-1:0] s4_prod [4];
  logic        [T_W-1:0]    s4_u;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_shr;

  always_comb begin
    sum = SUM_W'(s4_prod[0]) + SUM_W'(s4_prod[1])
        + SUM_W'(s4_prod[2]) + SUM_W'(s4_prod[3]);
    sum_shr = sum >>> FRAC_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s4_valid     <= wt_valid;
      result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_prod[0] <= $signed({1'b0, wt[0]}) * wt_item.p0;
      s4_prod[1] <= $signed({1'b0, wt[1]}) * wt_item.p1;
      s4_prod[2] <= $signed({1'b0, wt[2]}) * wt_item.p2;
      s4_prod[3] <= $signed({1'b0, wt[3]}) * wt_item.p3;
      s4_u       <= wt_u;

      result.point       <= sum_shr[COORD_W-1:0];
      result.one_minus_t <= s4_u;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cubic_bezier_fixed_eval_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word                         Handshake
// item      in         p0..p3, param_t (item_t)     item_valid / item_ready
// result    out        point, one_minus_t (result_t) result_valid / result_ready
//
// One word enters per cycle while the output register is not held; each result
// passes through the five register stages (three for the weights, one for the
// coordinate products, one for the sum and output register).
// Reset clears only the valid bits of the stages; payload registers are left.
// The whole pipeline holds when the output register is full and not taken, so
// item_ready is low exactly then and no word is lost or repeated.
module cubic_bezier_fixed_eval_core #(
  parameter int FRAC_SHIFT = cbez_pkg::FRAC_SHIFT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire cbez_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output cbez_pkg::result_t      result
);
  import cbez_pkg::*;

  // Width of a truncated Bernstein weight.
  localparam int WT_W = CUBE_W - FRAC_SHIFT;

  logic                 advance;
  logic                 wt_valid;
  logic [3:0][WT_W-1:0] wt;
  logic [T_W-1:0]       wt_u;
  item_t                wt_item;

  // All stages move together; they move whenever the output register is
  // empty or its word is being taken this cycle.
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  cbez_weights #(
    .FRAC_SHIFT (FRAC_SHIFT),
    .WT_W       (WT_W)
  ) u_weights (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .item_valid (item_valid),
    .item       (item),
    .wt_valid   (wt_valid),
    .wt         (wt),
    .wt_u       (wt_u),
    .wt_item    (wt_item)
  );

  cbez_blend #(
    .FRAC_SHIFT (FRAC_SHIFT),
    .WT_W       (WT_W)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .wt_valid     (wt_valid),
    .wt           (wt),
    .wt_u         (wt_u),
    .wt_item      (wt_item),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: tb/sv/bezier_point_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the Bezier evaluator. It predicts the coordinate and
// complement parameter for every accepted input word and checks each accepted
// result word against the oldest prediction.
module bezier_point_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  cbez_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  cbez_pkg::result_t result,
  output int                mismatch_count,
  output int                outstanding
);
  import cbez_pkg::*;

  localparam int     FRAC      = FRAC_SHIFT_DEF;
  localparam longint UNIT_STEP = longint'(1) << ((2 * FRAC) / 3);
  localparam int     REPORT_MAX = 10;

  result_t expected_points[$];
  int      errors = 0;

  // Exact Bernstein weights, each truncated, then a floor shift of the sum.
  function automatic result_t bezier_point(input item_t w);
    longint  t, u, w0, w1, w2, w3, acc;
    result_t r;
    t = longint'(w.param_t);
    if (t > UNIT_STEP) t = UNIT_STEP;
    u  = UNIT_STEP - t;
    w0 = (u * u * u) >>> FRAC;
    w1 = (3 * t * u * u) >>> FRAC;
    w2 = (3 * t * t * u) >>> FRAC;
    w3 = (t * t * t) >>> FRAC;
    acc = w0 * w.p0 + w1 * w.p1 + w2 * w.p2 + w3 * w.p3;
    acc = acc >>> FRAC;
    r.point       = acc[COORD_W-1:0];
    r.one_minus_t = u[T_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result word: point=%0d one_minus_t=%0d",
                     result.point, result.one_minus_t);
        end else begin
          want = expected_points.pop_front();
          if (result.point !== want.point || result.one_minus_t !== want.one_minus_t) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("result mismatch: point exp %0d got %0d, one_minus_t exp %0d got %0d",
                       want.point, result.point, want.one_minus_t, result.one_minus_t);
          end
        end
      end
      if (item_valid && item_ready)
        expected_points.push_back(bezier_point(item));
    end
    mismatch_count <= errors;
    outstanding    <= expected_points.size();
  end

endmodule

// File: tb/sv/cubic_bezier_fixed_eval_core_tb.sv
`timescale 1ns / 1ps

module cubic_bezier_fixed_eval_core_tb;
  import cbez_pkg::*;

  // The longest legal quiet stretch is the deliberate result hold-off below;
  // the watchdog allows many times that before giving up.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int RANDOM_WORDS   = 700;
  localparam int BLOCK_WORDS    = 100;
  // The block has five register stages; the drain wait covers them with margin.
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [T_W-1:0] T_ONE = 11'd1024;
  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int mismatch_count;
  int outstanding;
  int quiet_cycles = 0;

  // Idling controls, changed per block of random words by the stimulus process.
  // The sink picks up a hold-off request the next time it decides on a gap.
  bit source_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_results = 1'b0;

  always #10 clk = ~clk;

  cubic_bezier_fixed_eval_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  bezier_point_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Offers one input word. An optional gap first drops valid, then valid is
  // raised with the payload and held until the word is accepted. The caller
  // decides in the accepting step what comes next, so valid gets at most one
  // assignment per step.
  task automatic send_word(input logic signed [COORD_W-1:0] c0,
                           input logic signed [COORD_W-1:0] c1,
                           input logic signed [COORD_W-1:0] c2,
                           input logic signed [COORD_W-1:0] c3,
                           input logic [T_W-1:0] t);
    int gap;
    gap = source_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{p0: c0, p1: c1, p2: c2, p3: c3, param_t: t};
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  // Coordinates lean toward the rails and toward small values near zero now and
  // then, since the weighted sum is most likely to go wrong there; otherwise every bit pattern is allowed.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return COORD_W'($urandom_range(0, 64)) - 16'sd32;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // Parameters mostly cover the legal span, with its ends and some values
  // beyond one that the block must saturate.
  function automatic logic [T_W-1:0] pick_param();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return T_ONE;
      2, 3:    return T_W'($urandom_range(1025, 2047));
      default: return T_W'($urandom_range(0, 1024));
    endcase
  endfunction

  // Result sink. Before each word it may drop ready for a few cycles, and on
  // request it withholds ready for a long stretch so that the pipeline fills
  // and the input side stalls.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = sink_gaps ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL cubic_bezier_fixed_eval_core");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words: parameter ends, saturation, rails of the coordinates.
    send_word('0, '0, '0, '0, '0);
    send_word(C_MAX, C_MAX, C_MAX, C_MAX, '0);
    send_word(C_MIN, C_MIN, C_MIN, C_MIN, '0);
    send_word(C_MAX, C_MAX, C_MAX, C_MAX, T_ONE);
    send_word(C_MIN, C_MIN, C_MIN, C_MIN, T_ONE);
    send_word(C_MAX, C_MAX, C_MAX, C_MAX, 11'd512);
    send_word(C_MIN, C_MIN, C_MIN, C_MIN, 11'd512);
    // Parameters past one must behave exactly like one: result is p3, u is 0.
    send_word(16'sd100, -16'sd200, 16'sd300, -16'sd400, 11'd1025);
    send_word(16'sd100, -16'sd200, 16'sd300, -16'sd400, 11'd2047);
    send_word(C_MIN, C_MAX, C_MIN, C_MAX, 11'd1536);
    send_word(C_MIN, C_MAX, C_MAX, C_MIN, 11'd1);
    send_word(C_MAX, C_MIN, C_MIN, C_MAX, 11'd1023);
    send_word(C_MAX, C_MIN, C_MAX, C_MIN, 11'd341);
    send_word(C_MIN, C_MAX, C_MIN, C_MAX, 11'd683);
    // Small negative values expose a truncating instead of a flooring shift.
    send_word(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 11'd300);
    send_word(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 11'd700);
    send_word(16'sd1, 16'sd1, 16'sd1, 16'sd1, 11'd1000);
    send_word(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 11'h555);
    send_word(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 11'h2AA);

    // Random words in blocks. The first block idles on both sides, the second
    // not at all; later blocks choose at random. Two blocks start with a long
    // result hold-off while the source keeps offering.
    for (int blk = 0; blk < RANDOM_WORDS / BLOCK_WORDS; blk++) begin
      case (blk)
        0: begin
          source_gaps = 1'b1;
          sink_gaps = 1'b1;
        end
        1: begin
          source_gaps = 1'b0;
          sink_gaps = 1'b0;
        end
        default: begin
          source_gaps = ($urandom_range(0, 2) != 0);
          sink_gaps = ($urandom_range(0, 2) != 0);
        end
      endcase
      if (blk == 2 || blk == 5) begin
        source_gaps = 1'b0;
        hold_results = 1'b1;
      end
      for (int n = 0; n < BLOCK_WORDS; n++)
        send_word(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_param());
    end
    item_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("PASS cubic_bezier_fixed_eval_core");
    else
      $display("FAIL cubic_bezier_fixed_eval_core");
    $finish;
  end

endmodule
